/* design/rcc_pkg.sv */
package rcc_pkg;

    // Image geometry limits and derived counter widths
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Field widths of the register and data interfaces
    localparam int DIM_W   = 10;
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 8;
    localparam int PROD_W  = COEF_W + PIX_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CMP_W   = ((DIM_W > COL_W) ? DIM_W : COL_W) + 1;
    localparam int CMPR_W  = ((DIM_W > ROW_W) ? DIM_W : ROW_W) + 1;
    localparam int PIX_MAX = 255;

    // Register file layout
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_COEF_00      = 3'd2,
        REG_COEF_01      = 3'd3,
        REG_COEF_10      = 3'd4,
        REG_COEF_11      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dims_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] c00;
        logic signed [COEF_W-1:0] c01;
        logic signed [COEF_W-1:0] c10;
        logic signed [COEF_W-1:0] c11;
    } coef_t;

    // One classified item on its way from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] above;
        logic             col_zero;
        logic             row_zero;
        logic             frame_end;
    } q_entry_t;

endpackage

/* design/rcc_ram.sv */
module rcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Registered read returns the old word when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/rcc_front.sv */
module rcc_front
    import rcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dims_t            dims,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] pixel_in,
    input  logic             frame_start,
    output logic             push,
    output q_entry_t         push_data,
    input  logic             q_full
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              f_valid_reg, f_valid_next;
    logic [PIX_W-1:0]  f_pixel_reg;
    logic              f_col_zero_reg;
    logic              f_row_zero_reg;
    logic              f_end_reg;

    logic              accept;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [CMP_W-1:0]  width_eff;
    logic [CMPR_W-1:0] height_eff;
    logic [CMP_W-1:0]  col_p1;
    logic [CMPR_W-1:0] row_p1;
    logic              row_end;
    logic              img_end;
    logic [PIX_W-1:0]  above_raw;

    // Handshake: take an item when the holding stage is free or moves on
    assign push     = f_valid_reg && !q_full;
    assign accept   = in_valid && (!f_valid_reg || !q_full);
    assign in_stall = f_valid_reg && q_full;

    // Clamp the programmed geometry to the supported range
    always_comb
    begin
        width_eff  = CMP_W'(dims.width);
        height_eff = CMPR_W'(dims.height);
        if (width_eff == '0)
        begin
            width_eff = CMP_W'(1);
        end
        else if (width_eff > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        if (height_eff == '0)
        begin
            height_eff = CMPR_W'(1);
        end
        else if (height_eff > CMPR_W'(MAX_HEIGHT))
        begin
            height_eff = CMPR_W'(MAX_HEIGHT);
        end
    end

    // Position of the incoming item and the raster advance
    always_comb
    begin
        cur_col  = frame_start ? '0 : col_reg;
        cur_row  = frame_start ? '0 : row_reg;
        col_p1   = CMP_W'(cur_col) + CMP_W'(1);
        row_p1   = CMPR_W'(cur_row) + CMPR_W'(1);
        row_end  = (col_p1 >= width_eff);
        img_end  = row_end && (row_p1 >= height_eff);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = img_end ? '0 : row_p1[ROW_W-1:0];
            end
            else
            begin
                col_next = col_p1[COL_W-1:0];
                row_next = cur_row;
            end
        end
    end

    // Holding stage valid: fill on accept, drain on push
    always_comb
    begin
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
        else
        begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            f_valid_reg <= f_valid_next;
        end
    end

    // Capture the item's payload and position flags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_pixel_reg    <= pixel_in;
            f_col_zero_reg <= (cur_col == '0);
            f_row_zero_reg <= (cur_row == '0);
            f_end_reg      <= img_end;
        end
    end

    // Previous row: read the pixel above and replace it in the same edge
    rcc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (accept),
        .waddr (cur_col),
        .wdata (pixel_in),
        .re    (accept),
        .raddr (cur_col),
        .rdata (above_raw)
    );

    always_comb
    begin
        push_data.pixel     = f_pixel_reg;
        push_data.above     = above_raw;
        push_data.col_zero  = f_col_zero_reg;
        push_data.row_zero  = f_row_zero_reg;
        push_data.frame_end = f_end_reg;
    end

endmodule

/* design/rcc_queue.sv */
module rcc_queue
    import rcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/rcc_back.sv */
module rcc_back
    import rcc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  coef_t            coefs,
    input  logic             head_valid,
    input  q_entry_t         head_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] pixel_out,
    output logic             frame_end
);

    logic                     v1_reg, v1_next;
    logic                     ov_reg, ov_next;
    logic signed [PROD_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic                     end1_reg;
    logic [PIX_W-1:0]         prev_pix_reg;
    logic [PIX_W-1:0]         prev_above_reg;
    logic [PIX_W-1:0]         pixel_out_reg;
    logic                     frame_end_reg;

    logic                     ready_out;
    logic                     s1_ready;
    logic [PIX_W-1:0]         left_px;
    logic [PIX_W-1:0]         above_px;
    logic [PIX_W-1:0]         ul_px;
    logic signed [SUM_W-1:0]  sum;
    logic [PIX_W-1:0]         clamped;

    // Stage advance: each stage moves when the one after it has room
    assign ready_out = !ov_reg || !out_stall;
    assign s1_ready  = !v1_reg || ready_out;
    assign pop       = head_valid && s1_ready;

    // Zero the neighbors that fall outside the image
    always_comb
    begin
        left_px  = head_data.col_zero ? '0 : prev_pix_reg;
        above_px = head_data.row_zero ? '0 : head_data.above;
        ul_px    = (head_data.col_zero || head_data.row_zero) ? '0 : prev_above_reg;
    end

    // Stage one: four products of a signed weight and a pixel
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p00_reg        <= PROD_W'(coefs.c00) * PROD_W'($signed({1'b0, head_data.pixel}));
            p01_reg        <= PROD_W'(coefs.c01) * PROD_W'($signed({1'b0, left_px}));
            p10_reg        <= PROD_W'(coefs.c10) * PROD_W'($signed({1'b0, above_px}));
            p11_reg        <= PROD_W'(coefs.c11) * PROD_W'($signed({1'b0, ul_px}));
            end1_reg       <= head_data.frame_end;
            prev_pix_reg   <= head_data.pixel;
            prev_above_reg <= above_px;
        end
    end

    // Stage two: sum and clamp to the pixel range
    always_comb
    begin
        sum = SUM_W'(p00_reg) + SUM_W'(p01_reg) + SUM_W'(p10_reg) + SUM_W'(p11_reg);
        if (sum < SUM_W'(0))
        begin
            clamped = '0;
        end
        else if (sum > SUM_W'(PIX_MAX))
        begin
            clamped = PIX_W'(PIX_MAX);
        end
        else
        begin
            clamped = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && ready_out)
        begin
            pixel_out_reg <= clamped;
            frame_end_reg <= end1_reg;
        end
    end

    // Valid bits of both stages
    always_comb
    begin
        v1_next = v1_reg;
        ov_next = ov_reg;
        if (pop)
        begin
            v1_next = 1'b1;
        end
        else if (ready_out)
        begin
            v1_next = 1'b0;
        end
        if (ready_out)
        begin
            ov_next = v1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule

/* design/roberts_cross_convolve_2x2.sv */
// Results pass the front stage, queue, back stage one and output register.
// Throughput: one pixel per cycle while in_stall is low; the line store is read
// and written once per accepted pixel, and a two-entry queue absorbs back-end
// stalls. Reset (rst_n low, asynchronous) empties all stages and sets width 512,
// height 512 and weights 0, 1, -1, 0; the line store is not cleared.
module roberts_cross_convolve_2x2
    import rcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  pixel_in,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              frame_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    dims_t      dims_reg;
    coef_t      coefs_reg;
    logic       wr_en;
    reg_index_t reg_sel;
    logic       push;
    q_entry_t   push_data;
    logic       q_full;
    logic       pop;
    logic       head_valid;
    q_entry_t   head_data;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_index_t'(paddr[ADDR_W-1:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.width  <= DIM_W'(512);
            dims_reg.height <= DIM_W'(512);
            coefs_reg.c00   <= 8'sd0;
            coefs_reg.c01   <= 8'sd1;
            coefs_reg.c10   <= -8'sd1;
            coefs_reg.c11   <= 8'sd0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_IMAGE_WIDTH:  dims_reg.width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: dims_reg.height <= pwdata[DIM_W-1:0];
                REG_COEF_00:      coefs_reg.c00   <= pwdata[COEF_W-1:0];
                REG_COEF_01:      coefs_reg.c01   <= pwdata[COEF_W-1:0];
                REG_COEF_10:      coefs_reg.c10   <= pwdata[COEF_W-1:0];
                REG_COEF_11:      coefs_reg.c11   <= pwdata[COEF_W-1:0];
                default:          ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = DATA_W'(dims_reg.width);
            REG_IMAGE_HEIGHT: prdata = DATA_W'(dims_reg.height);
            REG_COEF_00:      prdata = DATA_W'(unsigned'(coefs_reg.c00));
            REG_COEF_01:      prdata = DATA_W'(unsigned'(coefs_reg.c01));
            REG_COEF_10:      prdata = DATA_W'(unsigned'(coefs_reg.c10));
            REG_COEF_11:      prdata = DATA_W'(unsigned'(coefs_reg.c11));
            default:          prdata = '0;
        endcase
    end

    rcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .dims        (dims_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    rcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    rcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coefs      (coefs_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .frame_end  (frame_end)
    );

endmodule

/* design/rcc_checker.sv */
module rcc_checker
    import rcc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] pixel_out,
    input logic             frame_end
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_out) && $stable(frame_end))
        else $error("stalled result changed");

    // Input backs up only after the output side has been held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid right after reset");

endmodule

bind roberts_cross_convolve_2x2 rcc_checker u_rcc_checker (.*);

/* sim/edge_filter_checker.sv */
`timescale 1ns / 1ps

module edge_filter_checker
    import rcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [PIX_W-1:0]  pixel_in,
    input  logic              frame_start,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [PIX_W-1:0]  pixel_out,
    input  logic              frame_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                results_owed
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } filtered_t;

    // Results still owed by the block, oldest first
    filtered_t                owed_pixels[$];

    // Shadow of the block's registers and window state
    logic [DIM_W-1:0]         width_reg;
    logic [DIM_W-1:0]         height_reg;
    logic signed [COEF_W-1:0] weight [4];
    logic [PIX_W-1:0]         prev_row [MAX_WIDTH];
    logic [PIX_W-1:0]         left_pix;
    logic [PIX_W-1:0]         upleft_pix;
    int unsigned              col_pos;
    int unsigned              row_pos;

    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned limit);
        int unsigned u;
        u = 32'(v);
        if (u == 0)
            return 1;
        if (u > limit)
            return limit;
        return u;
    endfunction

    // Run one pixel through the 2x2 window, then advance the raster position
    function automatic filtered_t convolve_pixel(input logic [PIX_W-1:0] pix,
                                                 input logic first);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int          above;
        int          left;
        int          upleft;
        int          acc;
        logic        row_end;
        filtered_t   res;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        if (first)
        begin
            col_pos    = 0;
            row_pos    = 0;
            left_pix   = '0;
            upleft_pix = '0;
        end
        col = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;

        // Neighbors outside the image count as zero
        above  = (row_pos > 0) ? int'(prev_row[col]) : 0;
        left   = (col > 0) ? int'(left_pix) : 0;
        upleft = (row_pos > 0 && col > 0) ? int'(upleft_pix) : 0;

        acc = int'(weight[0]) * int'(pix) + int'(weight[1]) * left
            + int'(weight[2]) * above + int'(weight[3]) * upleft;
        if (acc > PIX_MAX)
            acc = PIX_MAX;
        if (acc < 0)
            acc = 0;

        // A column or row at or past the last one ends it
        row_end  = (col + 1 >= w);
        res.last = row_end && (row_pos + 1 >= h);
        res.pixel = acc[PIX_W-1:0];

        upleft_pix    = above[PIX_W-1:0];
        prev_row[col] = pix;
        left_pix      = pix;
        if (row_end)
        begin
            col_pos = 0;
            row_pos = res.last ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col + 1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reg_index_t idx;
        filtered_t  want;
        if (!rst_n)
        begin
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_HEIGHT);
            weight[0]  = 8'sd0;
            weight[1]  = 8'sd1;
            weight[2]  = -8'sd1;
            weight[3]  = 8'sd0;
            left_pix   = '0;
            upleft_pix = '0;
            col_pos    = 0;
            row_pos    = 0;
            owed_pixels.delete();
            fail_count   = 0;
            results_owed = 0;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                idx = reg_index_t'(paddr[ADDR_W-1:2]);
                case (idx)
                    REG_IMAGE_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = pwdata[DIM_W-1:0];
                    REG_COEF_00, REG_COEF_01, REG_COEF_10, REG_COEF_11:
                        weight[idx - REG_COEF_00] = pwdata[COEF_W-1:0];
                    default: ;
                endcase
            end

            // Predict each accepted item
            if (in_valid && !in_stall)
                owed_pixels.push_back(convolve_pixel(pixel_in, frame_start));

            // Compare each delivered item with the oldest prediction
            if (out_valid === 1'b1 && !out_stall)
            begin
                if (owed_pixels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: extra item, expected none, actual pixel_out=%0d frame_end=%0b",
                             $time, pixel_out, frame_end);
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    if (pixel_out !== want.pixel)
                    begin
                        fail_count++;
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, want.pixel, pixel_out);
                    end
                    if (frame_end !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, want.last, frame_end);
                    end
                end
            end
            results_owed = owed_pixels.size();
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb
    import rcc_pkg::*;
();

    localparam int ITEM_TARGET = 1800;
    localparam int QUIET_TAIL  = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DIM_TOP     = (1 << DIM_W) - 1;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_stall;
    logic [PIX_W-1:0]  pixel_in    = '0;
    logic              frame_start = 1'b0;
    logic              out_valid;
    logic              out_stall   = 1'b0;
    logic [PIX_W-1:0]  pixel_out;
    logic              frame_end;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                results_owed;
    int                cycle_count = 0;
    int                items_sent  = 0;
    int                hold_cycles = 0;
    bit                send_gaps   = 1'b0;
    bit                recv_stalls = 1'b0;
    int unsigned       cur_width   = MAX_WIDTH;

    always #5 clk = ~clk;

    roberts_cross_convolve_2x2 u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_out   (pixel_out),
        .frame_end   (frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    edge_filter_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .frame_end    (frame_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold on request
    initial
    begin
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0 && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (recv_stalls && items_sent < ITEM_TARGET - QUIET_TAIL
                     && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one pixel, with an optional idle burst ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        if (send_gaps && items_sent < ITEM_TARGET - QUIET_TAIL
            && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_in    <= pix;
        frame_start <= fs;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic apb_write(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drain the block, then load geometry and weights
    task automatic write_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [COEF_W-1:0] c00, input logic [COEF_W-1:0] c01,
                                input logic [COEF_W-1:0] c10, input logic [COEF_W-1:0] c11);
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        apb_write(REG_IMAGE_WIDTH, DATA_W'(w));
        apb_write(REG_IMAGE_HEIGHT, DATA_W'(h));
        apb_write(REG_COEF_00, DATA_W'(c00));
        apb_write(REG_COEF_01, DATA_W'(c01));
        apb_write(REG_COEF_10, DATA_W'(c10));
        apb_write(REG_COEF_11, DATA_W'(c11));
    endtask

    function automatic logic [COEF_W-1:0] pick_weight();
        case ($urandom_range(0, 2))
            0:       return COEF_W'(int'($urandom_range(0, 2)) - 1);
            1:       return COEF_W'(int'($urandom_range(0, 8)) - 4);
            default: return COEF_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly small sizes; now and then zero, the maximum, or beyond it
    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned limit,
                                                  input int unsigned common_max);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return DIM_W'(limit);
            2:       return DIM_W'($urandom_range(limit + 1, DIM_TOP));
            3, 4, 5: return DIM_W'($urandom_range(common_max + 1, 4 * common_max));
            default: return DIM_W'($urandom_range(1, common_max));
        endcase
    endfunction

    initial
    begin
        logic [DIM_W-1:0] w_raw;
        logic [DIM_W-1:0] h_raw;
        int unsigned      w_eff;
        int unsigned      h_eff;
        int unsigned      img;
        int               n;
        int               mode;
        logic             fs;
        logic             fs_first;
        logic [PIX_W-1:0] pix;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default weights: left neighbor minus the pixel above, first row only
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd1, 1'b1);
        send_pixel(8'd255, 1'b0);

        // Largest weights saturate high
        write_config(10'd3, 10'd2, 8'd127, 8'd127, 8'd127, 8'd127);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b0);

        // Most negative weights clamp to zero; stop mid-row on the second row
        write_config(10'd3, 10'd2, 8'h80, 8'h80, 8'h80, 8'h80);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);

        // Shrink mid-image: zero width acts as one, position is past the end
        write_config(10'd0, 10'd1, 8'd1, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd3, 1'b0);

        // Oversized width acts as the maximum, zero height as one; grow needs a restart
        write_config(DIM_W'(DIM_TOP), 10'd0, 8'd0, 8'd127, 8'h80, 8'd1);
        send_pixel(8'd40, 1'b1);
        send_pixel(8'd50, 1'b0);
        send_pixel(8'd60, 1'b0);
        cur_width = MAX_WIDTH;

        // Random phases of whole images with random content
        for (int phase = 0; items_sent < ITEM_TARGET; phase++)
        begin
            w_raw = pick_dim(MAX_WIDTH, 8);
            h_raw = pick_dim(MAX_HEIGHT, 5);
            w_eff = 32'(w_raw);
            if (w_eff == 0)
                w_eff = 1;
            else if (w_eff > MAX_WIDTH)
                w_eff = MAX_WIDTH;
            h_eff = 32'(h_raw);
            if (h_eff == 0)
                h_eff = 1;
            else if (h_eff > MAX_HEIGHT)
                h_eff = MAX_HEIGHT;
            img   = w_eff * h_eff;
            n     = img * $urandom_range(1, 3);
            if (n > 160)
                n = $urandom_range(40, 160);

            write_config(w_raw, h_raw, pick_weight(), pick_weight(),
                         pick_weight(), pick_weight());

            // A wider row would read unwritten line entries, so restart the image
            fs_first  = (w_eff > cur_width) || ($urandom_range(0, 3) != 0);
            cur_width = w_eff;

            mode        = $urandom_range(0, 3);
            send_gaps   = mode[0];
            recv_stalls = mode[1];

            // Hold the output long enough for the block to back up its input
            if (phase == 2)
            begin
                if (n < 60)
                    n = 60;
                send_gaps   = 1'b0;
                hold_cycles = 150;
            end

            for (int k = 0; k < n; k++)
            begin
                if (k == 0)
                    fs = fs_first;
                else if (k % img == 0)
                    fs = 1'($urandom_range(0, 1));
                else
                    fs = ($urandom_range(0, 49) == 0);
                case ($urandom_range(0, 7))
                    0:       pix = '0;
                    1:       pix = '1;
                    default: pix = PIX_W'($urandom_range(0, 255));
                endcase
                send_pixel(pix, fs);
            end
        end

        // Drain and give the verdict
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* roberts_cross_convolve_2x2.f */
design/rcc_pkg.sv
design/rcc_ram.sv
design/rcc_front.sv
design/rcc_queue.sv
design/rcc_back.sv
design/roberts_cross_convolve_2x2.sv
design/rcc_checker.sv
sim/edge_filter_checker.sv
sim/tb.sv
